### rtl/core/kmm_pkg.sv
// kmm_pkg: shared widths, codes, state type and store control structs
// for the knight shortest-path search core; no dependencies
package kmm_pkg;

  localparam int MAX_SIDE = 128;
  localparam int SIDE_W   = $clog2(MAX_SIDE);
  localparam int SQUARES  = MAX_SIDE * MAX_SIDE;
  localparam int SQ_W     = 2 * SIDE_W;
  localparam int PTR_W    = SQ_W + 1;
  localparam int DIST_W   = 14;
  localparam int COORD_W  = 8;
  localparam int CFG_W    = 8;
  localparam int CFG_IDX_W = 1;
  localparam int NB_W     = 3;
  localparam logic [CFG_W-1:0] SIDE_RESET = 8'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOARD_ROWS = 1'b0,
    CFG_BOARD_COLS = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SEED,
    ST_POP,
    ST_DIST,
    ST_EXPAND,
    ST_NEXT,
    ST_FINISH
  } state_t;

  // memory controls from the sequencer
  typedef struct packed {
    logic              vis_we;
    logic [SQ_W-1:0]   vis_waddr;
    logic              vis_wdata;
    logic [SQ_W-1:0]   vis_raddr;
    logic              dist_we;
    logic [SQ_W-1:0]   dist_waddr;
    logic [DIST_W-1:0] dist_wdata;
    logic              dist_re;
    logic [SQ_W-1:0]   dist_raddr;
    logic              fifo_we;
    logic [SQ_W-1:0]   fifo_waddr;
    logic [SQ_W-1:0]   fifo_wdata;
    logic              fifo_re;
    logic [SQ_W-1:0]   fifo_raddr;
  } store_ctrl_t;

  // registered read data back to the sequencer
  typedef struct packed {
    logic              vis_q;
    logic [DIST_W-1:0] dist_q;
    logic [SQ_W-1:0]   fifo_q;
  } store_rd_t;

  function automatic logic signed [2:0] knight_dr(input logic [NB_W-1:0] k);
    logic signed [2:0] d;
    unique case (k)
      3'd0, 3'd1: d = 3'sd2;
      3'd2, 3'd3: d = -3'sd2;
      3'd4, 3'd6: d = 3'sd1;
      default:    d = -3'sd1;
    endcase
    return d;
  endfunction

  function automatic logic signed [2:0] knight_dc(input logic [NB_W-1:0] k);
    logic signed [2:0] d;
    unique case (k)
      3'd0, 3'd2: d = 3'sd1;
      3'd1, 3'd3: d = -3'sd1;
      3'd4, 3'd5: d = 3'sd2;
      default:    d = -3'sd2;
    endcase
    return d;
  endfunction

endpackage

### rtl/core/kmm_query_if.sv
// kmm_query_if: query channel (target square) with valid/ready handshake
// depends on kmm_pkg
interface kmm_query_if;
  import kmm_pkg::*;

  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] target_row;
  logic [COORD_W-1:0] target_col;

  modport source(output valid, output target_row, output target_col, input ready);
  modport sink(input valid, input target_row, input target_col, output ready);
endinterface

### rtl/core/kmm_result_if.sv
// kmm_result_if: result channel (move count, reachable) with valid/ready
// depends on kmm_pkg
interface kmm_result_if;
  import kmm_pkg::*;

  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] move_count;
  logic              reachable;

  modport source(output valid, output move_count, output reachable, input ready);
  modport sink(input valid, input move_count, input reachable, output ready);
endinterface

### rtl/core/kmm_neighbor.sv
// kmm_neighbor: shared move unit, one knight neighbor and its bounds check
// depends on kmm_pkg
module kmm_neighbor (
  input  logic [kmm_pkg::SQ_W-1:0]    sq,
  input  logic [kmm_pkg::NB_W-1:0]    k,
  input  logic [kmm_pkg::CFG_W-1:0]   rows,
  input  logic [kmm_pkg::CFG_W-1:0]   cols,
  output logic [kmm_pkg::SQ_W-1:0]    nsq,
  output logic                        in_bounds
);
  import kmm_pkg::*;

  logic signed [2:0] dr;
  logic signed [2:0] dc;
  logic signed [CFG_W:0] nr;
  logic signed [CFG_W:0] nc;

  assign dr = knight_dr(k);
  assign dc = knight_dc(k);

  assign nr = $signed({{(CFG_W + 1 - SIDE_W){1'b0}}, sq[SQ_W-1:SIDE_W]})
            + $signed({{(CFG_W - 2){dr[2]}}, dr});
  assign nc = $signed({{(CFG_W + 1 - SIDE_W){1'b0}}, sq[SIDE_W-1:0]})
            + $signed({{(CFG_W - 2){dc[2]}}, dc});

  assign in_bounds = !nr[CFG_W] && !nc[CFG_W]
                   && (nr[CFG_W-1:0] < rows) && (nc[CFG_W-1:0] < cols);
  assign nsq = {nr[SIDE_W-1:0], nc[SIDE_W-1:0]};
endmodule

### rtl/core/kmm_store.sv
// kmm_store: visited map, distance store and square fifo memories,
// each one write port and one registered read port; depends on kmm_pkg
module kmm_store (
  input  logic                 clk,
  input  kmm_pkg::store_ctrl_t ctrl,
  output kmm_pkg::store_rd_t   rd
);
  import kmm_pkg::*;

  logic              vis_mem  [SQUARES];
  logic [DIST_W-1:0] dist_mem [SQUARES];
  logic [SQ_W-1:0]   fifo_mem [SQUARES];

  always_ff @(posedge clk) begin
    if (ctrl.vis_we) begin
      vis_mem[ctrl.vis_waddr] <= ctrl.vis_wdata;
    end
    rd.vis_q <= vis_mem[ctrl.vis_raddr];
    if (ctrl.dist_we) begin
      dist_mem[ctrl.dist_waddr] <= ctrl.dist_wdata;
    end
    if (ctrl.dist_re) begin
      rd.dist_q <= dist_mem[ctrl.dist_raddr];
    end
    if (ctrl.fifo_we) begin
      fifo_mem[ctrl.fifo_waddr] <= ctrl.fifo_wdata;
    end
    if (ctrl.fifo_re) begin
      rd.fifo_q <= fifo_mem[ctrl.fifo_raddr];
    end
  end
endmodule

### rtl/core/kmm_seq.sv
// kmm_seq: search sequencer, fifo pointers, neighbor pipeline and result
// register; uses kmm_neighbor, drives kmm_store; depends on kmm_pkg
module kmm_seq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [kmm_pkg::CFG_W-1:0]    rows,
  input  logic [kmm_pkg::CFG_W-1:0]    cols,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [kmm_pkg::COORD_W-1:0]  in_row,
  input  logic [kmm_pkg::COORD_W-1:0]  in_col,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [kmm_pkg::DIST_W-1:0]   out_count,
  output logic                         out_reach,
  output kmm_pkg::store_ctrl_t         ctrl,
  input  kmm_pkg::store_rd_t           rd
);
  import kmm_pkg::*;

  state_t            state_r, state_nxt;
  logic [SQ_W-1:0]   tgt_r, tgt_nxt;
  logic [SQ_W-1:0]   clr_r, clr_nxt;
  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [PTR_W-1:0]  tail_r, tail_nxt;
  logic [SQ_W-1:0]   sq_r, sq_nxt;
  logic [NB_W-1:0]   k_r, k_nxt;
  logic              p_valid_r, p_valid_nxt;
  logic [SQ_W-1:0]   p_sq_r, p_sq_nxt;
  logic              found_r, found_nxt;
  logic [DIST_W-1:0] res_count_r, res_count_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DIST_W-1:0] out_count_r, out_count_nxt;
  logic              out_reach_r, out_reach_nxt;

  logic              accept;
  logic              on_board;
  logic              fresh;
  logic              fifo_room;
  logic              more;
  logic              out_free;
  logic [DIST_W-1:0] dist_inc;
  logic [SQ_W-1:0]   nsq;
  logic              nb_ok;

  kmm_neighbor u_nb (
    .sq        (sq_r),
    .k         (k_r),
    .rows      (rows),
    .cols      (cols),
    .nsq       (nsq),
    .in_bounds (nb_ok)
  );

  assign accept    = in_valid && in_ready;
  assign on_board  = (rows != '0) && (cols != '0) && (in_row != '0) && (in_col != '0)
                   && (in_row <= rows) && (in_col <= cols);
  // second pipeline stage: the neighbor tested last cycle was not yet seen
  assign fresh     = p_valid_r && !rd.vis_q;
  assign fifo_room = tail_r < PTR_W'(SQUARES);
  assign more      = head_r < tail_r;
  assign out_free  = !out_valid_r || out_ready;
  assign dist_inc  = rd.dist_q + DIST_W'(1);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = on_board ? ST_CLEAR : ST_FINISH;
        end
      end
      ST_CLEAR: begin
        if (clr_r == '1) begin
          state_nxt = ST_SEED;
        end
      end
      ST_SEED:   state_nxt = ST_POP;
      ST_POP:    state_nxt = (!found_r && more) ? ST_DIST : ST_FINISH;
      ST_DIST:   state_nxt = ST_EXPAND;
      ST_EXPAND: begin
        if (k_r == '1) begin
          state_nxt = ST_NEXT;
        end
      end
      ST_NEXT:   state_nxt = ST_POP;
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // outputs: handshake and memory controls
  always_comb begin
    in_ready = (state_r == ST_IDLE);
    ctrl     = '0;
    ctrl.vis_raddr = nsq;
    unique case (state_r)
      ST_CLEAR: begin
        ctrl.vis_we    = 1'b1;
        ctrl.vis_waddr = clr_r;
        ctrl.vis_wdata = 1'b0;
      end
      ST_SEED: begin
        ctrl.vis_we    = 1'b1;
        ctrl.vis_wdata = 1'b1;
        ctrl.dist_we   = 1'b1;
        ctrl.fifo_we   = 1'b1;
      end
      ST_POP: begin
        ctrl.fifo_re    = !found_r && more;
        ctrl.fifo_raddr = head_r[SQ_W-1:0];
      end
      ST_DIST: begin
        ctrl.dist_re    = 1'b1;
        ctrl.dist_raddr = rd.fifo_q;
      end
      default: begin
      end
    endcase
    if (fresh) begin
      ctrl.vis_we     = 1'b1;
      ctrl.vis_waddr  = p_sq_r;
      ctrl.vis_wdata  = 1'b1;
      ctrl.dist_we    = 1'b1;
      ctrl.dist_waddr = p_sq_r;
      ctrl.dist_wdata = dist_inc;
      ctrl.fifo_we    = fifo_room;
      ctrl.fifo_waddr = tail_r[SQ_W-1:0];
      ctrl.fifo_wdata = p_sq_r;
    end
  end

  // datapath registers
  always_comb begin
    tgt_nxt       = tgt_r;
    clr_nxt       = clr_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    sq_nxt        = sq_r;
    k_nxt         = k_r;
    p_valid_nxt   = 1'b0;
    p_sq_nxt      = nsq;
    found_nxt     = found_r;
    res_count_nxt = res_count_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_count_nxt = out_count_r;
    out_reach_nxt = out_reach_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          tgt_nxt       = {SIDE_W'(in_row - COORD_W'(1)), SIDE_W'(in_col - COORD_W'(1))};
          clr_nxt       = '0;
          found_nxt     = 1'b0;
          res_count_nxt = '0;
        end
      end
      ST_CLEAR:  clr_nxt = clr_r + SQ_W'(1);
      ST_SEED: begin
        head_nxt = '0;
        tail_nxt = PTR_W'(1);
        // target is the corner itself
        if (tgt_r == '0) begin
          found_nxt = 1'b1;
        end
      end
      ST_POP: begin
        if (!found_r && more) begin
          head_nxt = head_r + PTR_W'(1);
        end
      end
      ST_DIST: begin
        sq_nxt = rd.fifo_q;
        k_nxt  = '0;
      end
      ST_EXPAND: begin
        p_valid_nxt = nb_ok;
        k_nxt       = k_r + NB_W'(1);
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = found_r ? res_count_r : '0;
          out_reach_nxt = found_r;
        end
      end
      default: begin
      end
    endcase
    if (fresh) begin
      if (fifo_room) begin
        tail_nxt = tail_r + PTR_W'(1);
      end
      if (p_sq_r == tgt_r) begin
        found_nxt     = 1'b1;
        res_count_nxt = dist_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      p_valid_r   <= p_valid_nxt;
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tgt_r       <= tgt_nxt;
    clr_r       <= clr_nxt;
    sq_r        <= sq_nxt;
    k_r         <= k_nxt;
    p_sq_r      <= p_sq_nxt;
    res_count_r <= res_count_nxt;
    out_count_r <= out_count_nxt;
    out_reach_r <= out_reach_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_count = out_count_r;
  assign out_reach = out_reach_r;
endmodule

### rtl/core/knight_min_moves_bfs_core.sv
// knight_min_moves_bfs_core: top level, configuration registers and
// channel wiring; uses kmm_seq, kmm_store, kmm_pkg and the channel interfaces
//
// Each query beat names a 1-based target square; the core answers with the
// fewest knight moves from the corner (1,1) and a reachable flag, one result
// beat per query. Board rows and columns are written on the cfg port (reset
// 8 x 8, values above 128 act as 128); the user must write them only while
// the core is idle, as the core does not enforce this. A target off the
// board goes from idle straight to the result. Otherwise the core first
// sweeps its 16384-entry visited map, one entry per cycle, seeds the corner,
// then steps through every square taken from the search queue: queue read,
// distance read, the eight knight moves through the single neighbor unit one
// per cycle, and a drain step for the visited-map read pipeline. Queries are
// accepted one at a time; the next one may enter while the previous result
// still sits in the output register.
module knight_min_moves_bfs_core (
  input  logic                             clk,
  input  logic                             rst_n,
  kmm_query_if.sink                        in_ch,
  kmm_result_if.source                     out_ch,
  input  logic                             cfg_we,
  input  logic [kmm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [kmm_pkg::CFG_W-1:0]        cfg_wdata
);
  import kmm_pkg::*;

  logic [CFG_W-1:0] rows_r, rows_nxt;
  logic [CFG_W-1:0] cols_r, cols_nxt;
  logic [CFG_W-1:0] rows_sat;
  logic [CFG_W-1:0] cols_sat;
  store_ctrl_t      ctrl;
  store_rd_t        rd;

  always_comb begin
    rows_nxt = rows_r;
    cols_nxt = cols_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_BOARD_ROWS: rows_nxt = cfg_wdata;
        CFG_BOARD_COLS: cols_nxt = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= SIDE_RESET;
      cols_r <= SIDE_RESET;
    end else begin
      rows_r <= rows_nxt;
      cols_r <= cols_nxt;
    end
  end

  // sides above the board store size saturate
  assign rows_sat = (rows_r > CFG_W'(MAX_SIDE)) ? CFG_W'(MAX_SIDE) : rows_r;
  assign cols_sat = (cols_r > CFG_W'(MAX_SIDE)) ? CFG_W'(MAX_SIDE) : cols_r;

  kmm_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .rows      (rows_sat),
    .cols      (cols_sat),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_row    (in_ch.target_row),
    .in_col    (in_ch.target_col),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_count (out_ch.move_count),
    .out_reach (out_ch.reachable),
    .ctrl      (ctrl),
    .rd        (rd)
  );

  kmm_store u_store (
    .clk  (clk),
    .ctrl (ctrl),
    .rd   (rd)
  );
endmodule

### dv/tb_knight_min_moves_bfs_core.sv
// tb_knight_min_moves_bfs_core: self-checking bench for the knight shortest-path core
// needs kmm_pkg, kmm_query_if, kmm_result_if and knight_min_moves_bfs_core; the
// expected move counts come from a breadth-first search kept inside the bench
module tb_knight_min_moves_bfs_core;
  import kmm_pkg::*;

  localparam int QUIET_LIMIT = 800_000;
  localparam int RANDOM_QUERIES = 75;

  typedef struct {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } square_t;

  typedef struct {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [DIST_W-1:0]  moves;
    logic               reach;
  } tour_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  kmm_query_if  query_ch();
  kmm_result_if result_ch();

  knight_min_moves_bfs_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (query_ch),
    .out_ch    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // board registers as the core should hold them
  logic [CFG_W-1:0] rows_setting = SIDE_RESET;
  logic [CFG_W-1:0] cols_setting = SIDE_RESET;

  // search scratch, indexed row * MAX_SIDE + col
  bit                seen    [SQUARES];
  logic [DIST_W-1:0] hops    [SQUARES];
  int                sweep_q [SQUARES];

  square_t query_q[$];
  tour_t   tour_q[$];

  int  open_queries;
  int  fail_count;
  int  queries_sent;
  int  reach_count;
  int  miss_count;
  int  boards_tried;
  int  quiet_cycles;
  bit  query_taken;
  bit  result_taken;
  bit  result_waiting;
  int  query_gap;
  int  query_run;
  int  result_stall;
  int  result_run;

  function automatic int next_wait(inout int run);
    if (run > 0) begin
      run--;
      return 0;
    end
    if ($urandom_range(0, 5) == 0) begin
      run = $urandom_range(4, 16);
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  function automatic int eff_side(input logic [CFG_W-1:0] v);
    return (v > MAX_SIDE) ? MAX_SIDE : int'(v);
  endfunction

  function automatic void predict_tour(input logic [COORD_W-1:0] tr, input logic [COORD_W-1:0] tc,
                                       output logic [DIST_W-1:0] moves, output logic ok);
    int dr[8] = '{2, 2, -2, -2, 1, -1, 1, -1};
    int dc[8] = '{1, -1, 1, -1, 2, 2, -2, -2};
    int rows, cols, head, tail, sq, nr, nc, nsq, goal;
    rows  = eff_side(rows_setting);
    cols  = eff_side(cols_setting);
    moves = '0;
    ok    = 1'b0;
    if (rows == 0 || cols == 0 || tr == 0 || tc == 0 || tr > rows || tc > cols)
      return;
    goal = (int'(tr) - 1) * MAX_SIDE + (int'(tc) - 1);
    for (int r = 0; r < rows; r++)
      for (int c = 0; c < cols; c++)
        seen[r * MAX_SIDE + c] = 1'b0;
    seen[0]    = 1'b1;
    hops[0]    = '0;
    sweep_q[0] = 0;
    head = 0;
    tail = 1;
    while (head < tail && !ok) begin
      sq = sweep_q[head];
      head++;
      for (int k = 0; k < 8; k++) begin
        nr = sq / MAX_SIDE + dr[k];
        nc = sq % MAX_SIDE + dc[k];
        if (nr < 0 || nc < 0 || nr >= rows || nc >= cols)
          continue;
        nsq = nr * MAX_SIDE + nc;
        if (seen[nsq])
          continue;
        seen[nsq] = 1'b1;
        hops[nsq] = hops[sq] + 1'b1;
        sweep_q[tail] = nsq;
        tail++;
      end
      // search stops as soon as the target square is marked
      if (seen[goal])
        ok = 1'b1;
    end
    if (ok)
      moves = hops[goal];
  endfunction

  task automatic report_err(input string what);
    fail_count++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  task automatic queue_query(input int r, input int c);
    square_t s;
    s.row = r[COORD_W-1:0];
    s.col = c[COORD_W-1:0];
    query_q.push_back(s);
    open_queries++;
    queries_sent++;
  endtask

  task automatic settle();
    wait (open_queries == 0);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_BOARD_ROWS)
      rows_setting = v;
    else
      cols_setting = v;
  endtask

  task automatic set_board(input int rows, input int cols);
    write_reg(CFG_BOARD_ROWS, rows[CFG_W-1:0]);
    write_reg(CFG_BOARD_COLS, cols[CFG_W-1:0]);
    boards_tried++;
  endtask

  // query driver: one target per beat, random hold-off between beats
  always @(negedge clk) begin : drive_query
    square_t s;
    logic    nxt;
    if (rst_n) begin
      nxt = query_ch.valid;
      if (query_taken) begin
        query_taken = 1'b0;
        nxt         = 1'b0;
        query_gap   = next_wait(query_run);
      end
      if (!nxt) begin
        if (query_gap > 0) begin
          query_gap--;
        end else if (query_q.size() > 0) begin
          s = query_q.pop_front();
          query_ch.target_row <= s.row;
          query_ch.target_col <= s.col;
          nxt = 1'b1;
        end
      end
      query_ch.valid <= nxt;
    end
  end

  // result back-pressure: stall only counts down while a result is offered
  always @(negedge clk) begin : drive_ready
    logic nxt;
    if (rst_n) begin
      nxt = result_ch.ready;
      if (result_taken) begin
        result_taken = 1'b0;
        result_stall = next_wait(result_run);
        nxt          = (result_stall == 0);
      end else if (!nxt && result_waiting) begin
        if (result_stall == 0)
          nxt = 1'b1;
        else
          result_stall--;
      end
      result_ch.ready <= nxt;
    end
  end

  // beat capture on both channels, result check and watchdog
  always @(posedge clk) begin : watch_beats
    tour_t             t;
    logic [DIST_W-1:0] mv;
    logic              ok;
    bit                busy;
    if (rst_n) begin
      busy = cfg_we;
      if (query_ch.valid && query_ch.ready) begin
        predict_tour(query_ch.target_row, query_ch.target_col, mv, ok);
        t.row   = query_ch.target_row;
        t.col   = query_ch.target_col;
        t.moves = mv;
        t.reach = ok;
        tour_q.push_back(t);
        query_taken = 1'b1;
        busy        = 1'b1;
      end
      result_waiting = result_ch.valid;
      if (result_ch.valid && result_ch.ready) begin
        result_taken = 1'b1;
        busy         = 1'b1;
        if (tour_q.size() == 0) begin
          report_err("result beat with no query outstanding");
        end else begin
          t = tour_q.pop_front();
          open_queries--;
          if (result_ch.move_count !== t.moves)
            report_err($sformatf("target (%0d,%0d) board %0dx%0d: move_count %0d, want %0d",
                                 t.row, t.col, rows_setting, cols_setting,
                                 result_ch.move_count, t.moves));
          if (result_ch.reachable !== t.reach)
            report_err($sformatf("target (%0d,%0d) board %0dx%0d: reachable %b, want %b",
                                 t.row, t.col, rows_setting, cols_setting,
                                 result_ch.reachable, t.reach));
          if (t.reach)
            reach_count++;
          else
            miss_count++;
        end
      end
      if (busy)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d queries open", quiet_cycles, open_queries);
        $display("tb_knight_min_moves_bfs_core NOT OK");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int  rows, cols, er, ec, n, kind, r, c, random_sent;
    bit  near;
    query_ch.valid      = 1'b0;
    query_ch.target_row = '0;
    query_ch.target_col = '0;
    result_ch.ready     = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = CFG_BOARD_ROWS;
    cfg_wdata           = '0;
    rst_n               = 1'b0;
    result_stall        = next_wait(result_run);
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset board 8 x 8: corner, far corner, short hops, off-board targets
    queue_query(1, 1);
    queue_query(8, 8);
    queue_query(2, 3);
    queue_query(1, 2);
    queue_query(0, 5);
    queue_query(5, 0);
    queue_query(9, 1);
    queue_query(255, 255);
    queue_query(128, 128);
    settle();
    // 3 x 3: center square has no knight path
    set_board(3, 3);
    queue_query(2, 2);
    queue_query(3, 3);
    queue_query(1, 1);
    queue_query(3, 4);
    settle();
    set_board(1, 1);
    queue_query(1, 1);
    queue_query(1, 2);
    settle();
    // empty boards in either direction
    set_board(0, 5);
    queue_query(1, 1);
    settle();
    set_board(4, 0);
    queue_query(1, 1);
    settle();
    // oversized registers act as 128; far corner is the longest search
    set_board(255, 200);
    queue_query(128, 128);
    queue_query(129, 1);
    queue_query(1, 128);
    settle();
    set_board(2, 7);
    queue_query(2, 7);
    queue_query(2, 2);
    settle();

    random_sent = 0;
    while (random_sent < RANDOM_QUERIES) begin
      kind = $urandom_range(0, 7);
      near = 1'b0;
      if (kind == 0) begin
        rows = $urandom_range(100, 255);
        cols = $urandom_range(100, 255);
        near = 1'b1;
      end else if (kind == 1) begin
        rows = $urandom_range(0, 2);
        cols = $urandom_range(0, 20);
      end else begin
        rows = $urandom_range(1, 12);
        cols = $urandom_range(1, 12);
      end
      set_board(rows, cols);
      er = eff_side(rows[CFG_W-1:0]);
      ec = eff_side(cols[CFG_W-1:0]);
      n  = $urandom_range(4, 12);
      repeat (n) begin
        kind = $urandom_range(0, 9);
        if (kind < 7 && er > 0 && ec > 0) begin
          // big boards keep targets close so the search ends early
          r = near ? $urandom_range(1, 6) : $urandom_range(1, er);
          c = near ? $urandom_range(1, 6) : $urandom_range(1, ec);
        end else if (kind == 8) begin
          r = $urandom_range(0, 1) ? 0 : $urandom_range(1, 255);
          c = (r == 0) ? $urandom_range(0, 255) : 0;
        end else if (kind == 9) begin
          r = er + 1;
          c = $urandom_range(1, (ec > 0) ? ec : 1);
          if ($urandom_range(0, 1)) begin
            r = $urandom_range(1, (er > 0) ? er : 1);
            c = ec + 1;
          end
        end else begin
          r = $urandom_range(0, 255);
          c = $urandom_range(0, 255);
        end
        queue_query(r, c);
        random_sent++;
      end
      settle();
    end

    settle();
    repeat (20) @(posedge clk);
    $display("ran %0d queries over %0d board settings (reset board included)",
             queries_sent, boards_tried + 1);
    $display("results: %0d reachable, %0d unreachable, %0d mismatches",
             reach_count, miss_count, fail_count);
    if (fail_count == 0)
      $display("tb_knight_min_moves_bfs_core OK");
    else
      $display("tb_knight_min_moves_bfs_core NOT OK");
    $finish;
  end

endmodule
